/* design/zero_crossing_period_estimator_macros.svh */
// Assertion macros for the zero crossing period estimator.
`ifndef ZERO_CROSSING_PERIOD_ESTIMATOR_MACROS_SVH
`define ZERO_CROSSING_PERIOD_ESTIMATOR_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ZCPE_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("zcpe: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define ZCPE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("zcpe: next-cycle check failed");

`endif

/* design/zcpe_pkg.sv */
// Shared types and constants of the zero crossing period estimator.
package zcpe_pkg;

   localparam int COUNT_BITS = 32;
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

   // Status of the serial fraction divider.
   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

endpackage

/* design/zcpe_frac_div.sv */
// Bit-serial restoring divider for the crossing fraction, one quotient bit per cycle.
module zcpe_frac_div #(
   parameter int SAMPLE_BITS   = 16,
   parameter int FRACTION_BITS = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [SAMPLE_BITS:0]     numer,     // magnitude, below denom
   input  logic [SAMPLE_BITS:0]     denom,     // magnitude, non-zero
   output zcpe_pkg::div_stat_type   stat,
   output logic [FRACTION_BITS-1:0] quotient
);

   localparam int CNT_W = $clog2(FRACTION_BITS + 1);
   localparam logic [CNT_W-1:0] STEPS = CNT_W'(FRACTION_BITS);
   localparam logic [CNT_W-1:0] LAST  = CNT_W'(1);

   logic [SAMPLE_BITS+1:0]   rem_ff, rem_in;
   logic [SAMPLE_BITS:0]     den_ff;
   logic [FRACTION_BITS-1:0] quo_ff, quo_in;
   logic [CNT_W-1:0]         cnt_ff;
   logic                     busy_ff, done_ff;
   logic [SAMPLE_BITS+1:0]   shifted;
   logic                     fits;

   always_comb begin
      shifted = {rem_ff[SAMPLE_BITS:0], 1'b0};
      fits    = shifted >= {1'b0, den_ff};
      rem_in  = fits ? shifted - {1'b0, den_ff} : shifted;
      quo_in  = {quo_ff[FRACTION_BITS-2:0], fits};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         // one-cycle pulse after the last quotient bit
         done_ff <= !start && busy_ff && (cnt_ff == LAST);
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= STEPS;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - LAST;
            if (cnt_ff == LAST) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   // datapath, no reset needed
   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= {1'b0, numer};
         den_ff <= denom;
         quo_ff <= '0;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign quotient  = quo_ff;

endmodule

/* design/zero_crossing_period_estimator.sv */
// Top level of the zero crossing period estimator.
//
//  channel   ports                       direction  transfer when
//  request   req_valid/req_ready/sample  in         req_valid & req_ready
//  response  rsp_valid/rsp_ready/period  out        rsp_valid & rsp_ready
//  config    csr_wr_en/csr_wr_data       in         csr_wr_en high
//
// Steps: a sample with no falling crossing, or one whose fraction is a
// special case, is transferred and then updated in S_APPLY. A falling crossing
// that needs the division waits in S_DIV for the bit-serial divider, which
// produces one quotient bit per clock, and is then updated in S_APPLY.
// Reset is synchronous, active high; no clearing pass is needed.
// A stalled response holds the update; the next request is taken as soon as
// the update has been written to the response register.
module zero_crossing_period_estimator #(
   parameter int SAMPLE_BITS   = 16,
   parameter int FRACTION_BITS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [SAMPLE_BITS-1:0] req_sample,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [31:0]            rsp_period,
   input  logic                   csr_wr_en,
   input  logic [31:0]            csr_wr_data
);

`include "zero_crossing_period_estimator_macros.svh"

   localparam int CW = zcpe_pkg::COUNT_BITS;
   localparam logic [CW-1:0] ONE_Q = CW'(1) << FRACTION_BITS;
   localparam logic [FRACTION_BITS-1:0] FRAC_MAX = {FRACTION_BITS{1'b1}};

   typedef enum logic [1:0] {S_IDLE, S_DIV, S_APPLY} state_type;

   state_type                state_ff;
   logic [CW-1:0]            min_length_ff;
   logic [SAMPLE_BITS-1:0]   prev_ff, x_ff;
   logic [CW-1:0]            count_ff, count_in;
   logic [CW-1:0]            last_period_ff, last_period_in;
   logic                     above_ff, above_in;
   logic                     falls_ff, rises_ff;
   logic [FRACTION_BITS-1:0] frac_ff, frac_in;
   logic                     rsp_valid_ff;

   // crossing decision, taken at request transfer
   logic                     req_fire, count_ok, is_pos, is_neg, falls, rises;
   logic signed [SAMPLE_BITS:0] num, den;
   logic [SAMPLE_BITS:0]     an, ad;
   logic                     frac_zero, frac_full, need_div;

   // update
   logic [CW:0]              period_sum, count_sum;
   logic [CW-1:0]            frac_ext;
   logic                     out_free;

   zcpe_pkg::div_stat_type   div_stat;
   logic [FRACTION_BITS-1:0] div_quo;

   assign req_fire = req_valid && req_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign out_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      num      = {prev_ff[SAMPLE_BITS-1], prev_ff};
      den      = num - {req_sample[SAMPLE_BITS-1], req_sample};
      an       = num[SAMPLE_BITS] ? (SAMPLE_BITS+1)'(-num) : num;
      ad       = den[SAMPLE_BITS] ? (SAMPLE_BITS+1)'(-den) : den;
      count_ok = count_ff >= min_length_ff;
      is_neg   = req_sample[SAMPLE_BITS-1];
      is_pos   = !is_neg && (|req_sample);
      falls    = count_ok && is_neg && above_ff;
      rises    = count_ok && is_pos && !above_ff;
      // ratio is zero, negative or undefined: fraction 0
      frac_zero = (den == '0) || (num == '0) || (num[SAMPLE_BITS] != den[SAMPLE_BITS]);
      frac_full = an >= ad;
      need_div  = falls && !frac_zero && !frac_full;
      frac_in   = (frac_zero || !frac_full) ? '0 : FRAC_MAX;
   end

   always_comb begin
      frac_ext   = {{(CW-FRACTION_BITS){1'b0}}, frac_ff};
      period_sum = {1'b0, count_ff} + {1'b0, frac_ext};
      count_sum  = {1'b0, count_ff} + {1'b0, ONE_Q};
      last_period_in = last_period_ff;
      above_in       = above_ff;
      if (falls_ff) begin
         above_in       = 1'b0;
         last_period_in = period_sum[CW] ? zcpe_pkg::COUNT_MAX : period_sum[CW-1:0];
         count_in       = ONE_Q - frac_ext;   // remainder plus this sample
      end else begin
         if (rises_ff) begin
            above_in = 1'b1;
         end
         count_in = count_sum[CW] ? zcpe_pkg::COUNT_MAX : count_sum[CW-1:0];
      end
   end

   zcpe_frac_div #(
      .SAMPLE_BITS   (SAMPLE_BITS),
      .FRACTION_BITS (FRACTION_BITS)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (req_fire && need_div),
      .numer    (an),
      .denom    (ad),
      .stat     (div_stat),
      .quotient (div_quo)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         min_length_ff  <= '0;
         prev_ff        <= '0;
         count_ff       <= '0;
         last_period_ff <= '0;
         above_ff       <= 1'b1;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            min_length_ff <= csr_wr_data;
         end
         // drained, unless an update refills it in the same cycle
         if (rsp_valid_ff && rsp_ready && state_ff != S_APPLY) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_fire) begin
                  state_ff <= need_div ? S_DIV : S_APPLY;
               end
            end
            S_DIV: begin
               if (div_stat.done) begin
                  state_ff <= S_APPLY;
               end
            end
            S_APPLY: begin
               // wait until the response register is free
               if (out_free) begin
                  prev_ff        <= x_ff;
                  count_ff       <= count_in;
                  last_period_ff <= last_period_in;
                  above_ff       <= above_in;
                  rsp_valid_ff   <= 1'b1;
                  state_ff       <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // per-item datapath, no reset needed
   always_ff @(posedge clock) begin
      if (req_fire) begin
         x_ff     <= req_sample;
         falls_ff <= falls;
         rises_ff <= rises;
         frac_ff  <= frac_in;
      end else if (state_ff == S_DIV && div_stat.done) begin
         frac_ff <= div_quo;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_period = last_period_ff;

   `ZCPE_ASSERT_IMPL(a_ready_div_idle, clock, reset, req_ready, !div_stat.busy)
   `ZCPE_ASSERT_IMPL(a_done_in_div, clock, reset, div_stat.done, state_ff == S_DIV)
   `ZCPE_ASSERT_NEXT(a_fast_path, clock, reset, req_fire && !need_div, state_ff == S_APPLY)
   `ZCPE_ASSERT_NEXT(a_apply_shows, clock, reset, state_ff == S_APPLY && out_free,
                     rsp_valid_ff && state_ff == S_IDLE)

endmodule
